>>> design/rgb_to_hsv_converter_core_defines.svh
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared checking macros for the converter top level
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define RHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RHC_ASSERT_NEVER(label, expr, msg) \
    `RHC_ASSERT(label, !(expr), msg)

`endif

>>> design/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// constants and types shared by the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned FRAC_W      = 6;
    localparam int unsigned CMAX        = (1 << CH_W) - 1;
    localparam int unsigned FX_SCALE    = 1 << FRAC_W;
    localparam int unsigned PCT_SCALE   = 100 * FX_SCALE;

    localparam int unsigned HUE_SIXTH      = 60;
    localparam int unsigned HUE_THIRD      = 120;
    localparam int unsigned HUE_TWO_THIRDS = 240;
    localparam int unsigned HUE_FULL       = 360;

    localparam int unsigned HUE_W       = 15;
    localparam int unsigned PCT_W       = 13;
    localparam int unsigned NUM_W       = $clog2(HUE_FULL * CMAX);
    localparam int unsigned CALC_W      = NUM_W + 2;
    localparam int unsigned HUE_DVD_W   = NUM_W + FRAC_W;
    localparam int unsigned PCT_DVD_W   = $clog2(CMAX * PCT_SCALE + 1);
    localparam int unsigned DIV_STEPS   = HUE_W;
    localparam int unsigned DIV_W       = (HUE_DVD_W > CH_W + DIV_STEPS) ?
                                          HUE_DVD_W : CH_W + DIV_STEPS;

    localparam int unsigned BRI_MULT    = CMAX + 2;
    localparam int unsigned BRI_PROD_W  = PCT_DVD_W + CH_W + 1;

    localparam int unsigned IN_DATA_W   = ((3 * CH_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELD_W = HUE_W + 2 * PCT_W;
    localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CH_W-1:0]  delta;
        logic [CH_W-1:0]  max_ch;
        logic             black;
        logic             grey;
    } cls_t;

endpackage

`default_nettype wire

>>> design/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// input register and pixel classification: max, delta, hue numerator
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rgbhsv_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                                  push_valid,
    input  wire logic                             push_ready,
    output rgbhsv_pkg::cls_t                      push_data
);
    import rgbhsv_pkg::*;

    logic            in_valid_reg, in_valid_next;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;
    logic            accept;

    assign s_axis_tready = !in_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = in_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= s_axis_tdata[CH_W-1:0];
            green_reg <= s_axis_tdata[2*CH_W-1:CH_W];
            blue_reg  <= s_axis_tdata[3*CH_W-1:2*CH_W];
        end
    end

    always_comb
    begin
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   mn;
        logic [CH_W-1:0]   dd;
        logic [CALC_W-1:0] base;
        logic [CH_W-1:0]   pos;
        logic [CH_W-1:0]   neg;
        logic [CALC_W-1:0] num;

        mx = red_reg;
        if (green_reg > mx)
        begin
            mx = green_reg;
        end
        if (blue_reg > mx)
        begin
            mx = blue_reg;
        end
        mn = red_reg;
        if (green_reg < mn)
        begin
            mn = green_reg;
        end
        if (blue_reg < mn)
        begin
            mn = blue_reg;
        end
        dd = mx - mn;

        // first channel equal to max picks the sector
        if (red_reg == mx)
        begin
            base = (green_reg < blue_reg) ? CALC_W'(dd) * CALC_W'(HUE_FULL) : '0;
            pos  = green_reg;
            neg  = blue_reg;
        end
        else if (green_reg == mx)
        begin
            base = CALC_W'(dd) * CALC_W'(HUE_THIRD);
            pos  = blue_reg;
            neg  = red_reg;
        end
        else
        begin
            base = CALC_W'(dd) * CALC_W'(HUE_TWO_THIRDS);
            pos  = red_reg;
            neg  = green_reg;
        end
        num = base + CALC_W'(pos) * CALC_W'(HUE_SIXTH) - CALC_W'(neg) * CALC_W'(HUE_SIXTH);

        push_data.num    = num[NUM_W-1:0];
        push_data.delta  = dd;
        push_data.max_ch = mx;
        push_data.black  = (mx == '0);
        push_data.grey   = (dd == '0);
    end

endmodule

`default_nettype wire

>>> design/rgbhsv_queue.sv
// ----------------------------------------------------------------------------
// rgbhsv_queue
// two-entry register queue between classification and arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire rgbhsv_pkg::cls_t  push_data,
    output logic                   pop_valid,
    input  wire logic              pop,
    output rgbhsv_pkg::cls_t       pop_data
);
    import rgbhsv_pkg::*;

    logic head_valid_reg, head_valid_next;
    logic tail_valid_reg, tail_valid_next;
    cls_t head_reg, head_next;
    cls_t tail_reg, tail_next;
    logic push;

    assign push_ready = !tail_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (pop && head_valid_reg)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = push;
                tail_next       = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_next       = push_data;
            end
            else
            begin
                tail_valid_next = 1'b1;
                tail_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

>>> design/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// pipelined hue and saturation dividers, brightness scaling, output register
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    output logic                                   pop,
    input  wire rgbhsv_pkg::cls_t                  pop_data,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rgbhsv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                   m_axis_tuser
);
    import rgbhsv_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0]     hrem;
        logic [DIV_STEPS-1:0] hq;
        logic [DIV_W-1:0]     srem;
        logic [DIV_STEPS-1:0] sq;
        logic [CH_W-1:0]      delta;
        logic [CH_W-1:0]      max_ch;
        logic [PCT_DVD_W-1:0] bx;
        logic [PCT_W-1:0]     bq;
        logic                 black;
        logic                 grey;
    } stage_t;

    stage_t st_reg [0:DIV_STEPS];
    stage_t st_next [0:DIV_STEPS];
    logic   vld_reg [0:DIV_STEPS];

    logic             out_valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [PCT_W-1:0] sat_reg, sat_next;
    logic [PCT_W-1:0] bri_reg, bri_next;
    logic             undef_reg;
    logic             advance;

    assign advance = !out_valid_reg || m_axis_tready;
    assign pop     = advance && pop_valid;

    // entry stage: dividends from the classified item
    always_comb
    begin
        st_next[0].hrem   = DIV_W'({pop_data.num, {FRAC_W{1'b0}}});
        st_next[0].hq     = '0;
        st_next[0].srem   = DIV_W'(pop_data.delta) * DIV_W'(PCT_SCALE);
        st_next[0].sq     = '0;
        st_next[0].delta  = pop_data.delta;
        st_next[0].max_ch = pop_data.max_ch;
        st_next[0].bx     = PCT_DVD_W'(pop_data.max_ch) * PCT_DVD_W'(PCT_SCALE);
        st_next[0].bq     = '0;
        st_next[0].black  = pop_data.black;
        st_next[0].grey   = pop_data.grey;
    end

    // one quotient bit per stage, msb first
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        localparam int unsigned K = DIV_STEPS - i;

        always_comb
        begin
            logic [DIV_W-1:0]      hdiv;
            logic [DIV_W-1:0]      sdiv;
            logic [BRI_PROD_W-1:0] bprod;
            logic [PCT_DVD_W-1:0]  brem;

            st_next[i] = st_reg[i-1];
            hdiv       = DIV_W'(st_reg[i-1].delta) << K;
            sdiv       = DIV_W'(st_reg[i-1].max_ch) << K;
            if (st_reg[i-1].hrem >= hdiv)
            begin
                st_next[i].hrem  = st_reg[i-1].hrem - hdiv;
                st_next[i].hq[K] = 1'b1;
            end
            if (st_reg[i-1].srem >= sdiv)
            begin
                st_next[i].srem  = st_reg[i-1].srem - sdiv;
                st_next[i].sq[K] = 1'b1;
            end

            bprod = '0;
            brem  = '0;
            if (i == 1)
            begin
                // reciprocal estimate of x / cmax, at most two below
                bprod = BRI_PROD_W'(st_reg[i-1].bx) * BRI_PROD_W'(BRI_MULT);
                st_next[i].bq = PCT_W'(bprod >> (2 * CH_W));
            end
            else if (i == 2)
            begin
                brem = st_reg[i-1].bx -
                       PCT_DVD_W'(st_reg[i-1].bq) * PCT_DVD_W'(CMAX);
                if (brem >= PCT_DVD_W'(2 * CMAX))
                begin
                    st_next[i].bq = st_reg[i-1].bq + PCT_W'(2);
                end
                else if (brem >= PCT_DVD_W'(CMAX))
                begin
                    st_next[i].bq = st_reg[i-1].bq + PCT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        hue_next = (st_reg[DIV_STEPS].black || st_reg[DIV_STEPS].grey) ?
                   '0 : st_reg[DIV_STEPS].hq[HUE_W-1:0];
        sat_next = st_reg[DIV_STEPS].black ? '0 : st_reg[DIV_STEPS].sq[PCT_W-1:0];
        bri_next = st_reg[DIV_STEPS].bq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= pop_valid;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            out_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                st_reg[j] <= st_next[j];
            end
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            bri_reg   <= bri_next;
            undef_reg <= st_reg[DIV_STEPS].black;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, bri_reg, sat_reg, hue_reg};
    assign m_axis_tuser  = undef_reg;

endmodule

`default_nettype wire

>>> design/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: input register, queue, divider pipeline and output register from input to output item
// throughput one item per cycle while the output is not stalled, set by the 15-stage divider pipeline
// a stalled output holds the whole arithmetic pipeline; reset clears all valids
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_hsv_converter_core_defines.svh"

module rgb_to_hsv_converter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // red, green, blue
    input  wire logic [rgbhsv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // hue, saturation, brightness, zero pad
    output logic [rgbhsv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // hue_undefined, set only for black items
    output logic                                   m_axis_tuser
);
    import rgbhsv_pkg::*;

    logic push_valid;
    logic push_ready;
    cls_t push_data;
    logic pop_valid;
    logic pop;
    cls_t pop_data;

    rgbhsv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    rgbhsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    rgbhsv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `RHC_ASSERT_NEVER(a_hue_range, m_axis_tvalid && (m_axis_tdata[HUE_W-1:0] >= HUE_W'(HUE_FULL * FX_SCALE)), "hue out of range")
    `RHC_ASSERT(a_pct_range, m_axis_tvalid |-> (m_axis_tdata[HUE_W+PCT_W-1:HUE_W] <= PCT_W'(PCT_SCALE)) && (m_axis_tdata[OUT_FIELD_W-1:HUE_W+PCT_W] <= PCT_W'(PCT_SCALE)), "percent out of range")
    `RHC_ASSERT(a_black, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[OUT_FIELD_W-1:0] == '0), "black item not all zero")
    `RHC_ASSERT_NEVER(a_queue_drop, push_valid && !push_ready && !pop_valid, "queue full while empty")

endmodule

`default_nettype wire
